// ===== design/tlcf_pkg.sv =====
package tlcf_pkg;

  // Register field width and the saturation limits of the counters.
  localparam int CFG_W     = 13;
  localparam int BLACK_W   = 13;
  localparam int CUT_W     = 12;
  localparam int GRAY_W    = 8;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam logic [BLACK_W-1:0] BLACK_SAT = '1;
  localparam logic [CUT_W-1:0]   CUT_SAT   = '1;

  // Default size limits handed to the top level parameters.
  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RST     = 13'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST    = 13'd1024;
  localparam logic [CFG_W-1:0] MIN_BLACK_RST = 13'd82;
  localparam logic [CFG_W-1:0] GAP_MIN_RST   = 13'd7;

  // Register indexes (word address).
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_ROW_MIN_BLACK = 2'd2,
    REG_GAP_MIN_ROWS  = 2'd3
  } reg_index_t;

  // Kind of a result transaction.
  typedef enum logic {
    KIND_CUT    = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_t;

  // One result as held in the output queue.
  typedef struct packed {
    result_kind_t     kind;
    logic [CUT_W-1:0] cut_row;
    logic [CUT_W-1:0] cut_total;
    logic             enough;
    logic             last;
  } result_t;

endpackage

// ===== design/tlcf_if.sv =====
// Pixel channel: one grey pixel per transaction.
interface tlcf_pix_if;
  logic                        valid;
  logic                        ready;
  logic [tlcf_pkg::GRAY_W-1:0] pixel_gray;
  logic                        first_pixel;

  modport source (output valid, output pixel_gray, output first_pixel, input ready);
  modport sink   (input valid, input pixel_gray, input first_pixel, output ready);
endinterface

// Result channel: one cut or end-of-image status per transaction.
interface tlcf_res_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [tlcf_pkg::CUT_W-1:0] cut_row;
  logic [tlcf_pkg::CUT_W-1:0] cut_total;
  logic                       enough_cuts;
  logic                       last_result;

  modport source (output valid, output result_kind, output cut_row, output cut_total,
                  output enough_cuts, output last_result, input ready);
  modport sink   (input valid, input result_kind, input cut_row, input cut_total,
                  input enough_cuts, input last_result, output ready);
endinterface

// ===== design/text_line_cut_finder.sv =====
// Text line cut finder.
// Pixels enter in raster order on in_pix, one per transaction; first_pixel
// marks the start of an image and drops any partial image in progress. A pixel
// with grey value 0 is black. At each row end the row is classed as text or
// blank, and each long enough run of blank rows gives a cut transaction on
// out_res at the run's midpoint. The last row of an image also gives a status
// transaction with the cut count; last_result marks the final result of a pixel.
// Throughput is one pixel per cycle while the queue has room for two results. A
// pixel is held in the input register and its results are written to a
// four-entry result queue, whose head drives out_res.
// The queue takes the cut and the status of one pixel together; in_pix.ready
// drops while the input register is full and fewer than two queue entries are
// free, so a stalled receiver stops pixels after at most four pending results.
// The user must write registers over the APB-style cfg_ port only while idle;
// the block does not enforce it. Reset (rst_n low, synchronous) empties the
// queue, clears all image counters and restores the register defaults: width
// 1024, height 1024, 82 black pixels per text row, gap of 7 rows.
module text_line_cut_finder #(
  parameter int MAX_WIDTH  = tlcf_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = tlcf_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tlcf_pix_if.sink                      in_pix,
  tlcf_res_if.source                    out_res,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tlcf_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [tlcf_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [tlcf_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CFG_W   = tlcf_pkg::CFG_W;
  localparam int BLACK_W = tlcf_pkg::BLACK_W;
  localparam int CUT_W   = tlcf_pkg::CUT_W;
  localparam int GRAY_W  = tlcf_pkg::GRAY_W;
  localparam int APB_DW  = tlcf_pkg::APB_DW;
  localparam int CIDX_W  = $clog2(MAX_WIDTH);
  localparam int COL_W   = CIDX_W + 1;
  localparam int RIDX_W  = $clog2(MAX_HEIGHT);
  localparam int ROW_W   = RIDX_W + 1;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // Configuration registers.
  logic [CFG_W-1:0] image_width_r, image_height_r, row_min_black_r, gap_min_rows_r;
  logic             cfg_wr;
  tlcf_pkg::reg_index_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = tlcf_pkg::reg_index_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= tlcf_pkg::WIDTH_RST;
      image_height_r  <= tlcf_pkg::HEIGHT_RST;
      row_min_black_r <= tlcf_pkg::MIN_BLACK_RST;
      gap_min_rows_r  <= tlcf_pkg::GAP_MIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tlcf_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_pwdata[CFG_W-1:0];
        tlcf_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_pwdata[CFG_W-1:0];
        tlcf_pkg::REG_ROW_MIN_BLACK: row_min_black_r <= cfg_pwdata[CFG_W-1:0];
        tlcf_pkg::REG_GAP_MIN_ROWS:  gap_min_rows_r  <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      tlcf_pkg::REG_IMAGE_WIDTH:   cfg_prdata = APB_DW'(image_width_r);
      tlcf_pkg::REG_IMAGE_HEIGHT:  cfg_prdata = APB_DW'(image_height_r);
      tlcf_pkg::REG_ROW_MIN_BLACK: cfg_prdata = APB_DW'(row_min_black_r);
      tlcf_pkg::REG_GAP_MIN_ROWS:  cfg_prdata = APB_DW'(gap_min_rows_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, oversize acts as the maximum.
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [CFG_W-1:0] gap_eff;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(image_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height_r);
    end
    gap_eff = (gap_min_rows_r == '0) ? CFG_W'(1) : gap_min_rows_r;
  end

  // Result queue control, needed by the input register handshake.
  logic [QCNT_W-1:0] q_count_r, q_count_nxt;
  logic              q_room2;
  assign q_room2 = (q_count_r <= QCNT_W'(QDEPTH - 2));

  // Input register.
  logic              s1_valid_r;
  logic [GRAY_W-1:0] s1_gray_r;
  logic              s1_first_r;
  logic              s1_fire;
  logic              in_take;

  assign s1_fire      = s1_valid_r && q_room2;
  assign in_pix.ready = !s1_valid_r || q_room2;
  assign in_take      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_gray_r  <= in_pix.pixel_gray;
      s1_first_r <= in_pix.first_pixel;
    end
  end

  // Image state.
  logic [CIDX_W-1:0]  col_r;
  logic [RIDX_W-1:0]  row_r;
  logic [BLACK_W-1:0] black_r;
  logic               blank_r;
  logic [RIDX_W-1:0]  start_r;
  logic [CUT_W-1:0]   cuts_r;

  logic [CIDX_W-1:0]  col_nxt, col_base;
  logic [RIDX_W-1:0]  row_nxt, row_base;
  logic [BLACK_W-1:0] black_nxt, black_base, black_inc;
  logic               blank_nxt, blank_base, blank_a;
  logic [RIDX_W-1:0]  start_nxt, start_base, start_a;
  logic [CUT_W-1:0]   cuts_nxt, cuts_base, cuts_a, cuts_b;

  logic [COL_W-1:0]   col_inc;
  logic [ROW_W-1:0]   row_next, len1, len2, mid1, mid2;
  logic               row_end, text_row, img_end, cut1, cut2, cut_any;
  logic [1:0]         n_res;
  tlcf_pkg::result_t  res0, res1, cut_res, stat_res;

  // Per-pixel update: counting, row classification and run closing.
  always_comb begin
    // A first pixel clears the image state before it is counted.
    col_base   = s1_first_r ? '0 : col_r;
    row_base   = s1_first_r ? '0 : row_r;
    black_base = s1_first_r ? '0 : black_r;
    blank_base = s1_first_r ? 1'b0 : blank_r;
    start_base = s1_first_r ? '0 : start_r;
    cuts_base  = s1_first_r ? '0 : cuts_r;

    black_inc = black_base;
    if (s1_gray_r == '0 && black_base != tlcf_pkg::BLACK_SAT) begin
      black_inc = black_base + BLACK_W'(1);
    end
    col_inc  = {1'b0, col_base} + COL_W'(1);
    row_end  = (col_inc >= w_eff);
    text_row = (black_inc >= row_min_black_r);

    // A text row closes an open blank run.
    len1 = {1'b0, row_base} - {1'b0, start_base};
    mid1 = {1'b0, start_base} + (len1 >> 1);
    cut1 = text_row && blank_base && (32'(len1) >= 32'(gap_eff));
    blank_a = !text_row;
    start_a = (!text_row && !blank_base) ? row_base : start_base;
    cuts_a  = cuts_base;
    if (cut1 && cuts_base != tlcf_pkg::CUT_SAT) begin
      cuts_a = cuts_base + CUT_W'(1);
    end

    // The image end closes a run still open.
    row_next = {1'b0, row_base} + ROW_W'(1);
    img_end  = row_end && (row_next >= h_eff);
    len2 = h_eff - {1'b0, start_a};
    mid2 = {1'b0, start_a} + (len2 >> 1);
    cut2 = img_end && blank_a && (32'(len2) >= 32'(gap_eff));
    cuts_b = cuts_a;
    if (cut2 && cuts_a != tlcf_pkg::CUT_SAT) begin
      cuts_b = cuts_a + CUT_W'(1);
    end
    cut_any = row_end && (cut1 || cut2);

    // Result words.
    cut_res.kind      = tlcf_pkg::KIND_CUT;
    cut_res.cut_row   = cut1 ? CUT_W'(mid1) : CUT_W'(mid2);
    cut_res.cut_total = cuts_b;
    cut_res.enough    = 1'b0;
    cut_res.last      = !img_end;
    stat_res.kind      = tlcf_pkg::KIND_STATUS;
    stat_res.cut_row   = '0;
    stat_res.cut_total = cuts_b;
    stat_res.enough    = (cuts_b >= CUT_W'(2));
    stat_res.last      = 1'b1;
    res0  = cut_any ? cut_res : stat_res;
    res1  = stat_res;
    n_res = 2'(cut_any) + 2'(img_end);

    // Next state.
    col_nxt   = CIDX_W'(col_inc);
    row_nxt   = row_base;
    black_nxt = black_inc;
    blank_nxt = blank_base;
    start_nxt = start_base;
    cuts_nxt  = cuts_base;
    if (img_end) begin
      col_nxt   = '0;
      row_nxt   = '0;
      black_nxt = '0;
      blank_nxt = 1'b0;
      start_nxt = '0;
      cuts_nxt  = '0;
    end else if (row_end) begin
      col_nxt   = '0;
      row_nxt   = RIDX_W'(row_next);
      black_nxt = '0;
      blank_nxt = blank_a;
      start_nxt = start_a;
      cuts_nxt  = cuts_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      black_r <= '0;
      blank_r <= 1'b0;
      start_r <= '0;
      cuts_r  <= '0;
    end else if (s1_fire) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      black_r <= black_nxt;
      blank_r <= blank_nxt;
      start_r <= start_nxt;
      cuts_r  <= cuts_nxt;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  tlcf_pkg::result_t q_mem [QDEPTH];
  logic [QPTR_W-1:0] q_wr_r, q_rd_r;
  logic [QPTR_W-1:0] q_wr1;
  logic [1:0]        q_push;
  logic              q_pop;
  tlcf_pkg::result_t q_head;

  assign q_push = s1_fire ? n_res : 2'd0;
  assign q_pop  = out_res.valid && out_res.ready;
  assign q_wr1  = q_wr_r + QPTR_W'(1);
  assign q_count_nxt = q_count_r + QCNT_W'(q_push) - QCNT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (q_push != 2'd0) begin
      q_mem[q_wr_r] <= res0;
    end
    if (q_push == 2'd2) begin
      q_mem[q_wr1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r    <= '0;
      q_rd_r    <= '0;
      q_count_r <= '0;
    end else begin
      q_wr_r    <= q_wr_r + QPTR_W'(q_push);
      q_rd_r    <= q_rd_r + QPTR_W'(q_pop);
      q_count_r <= q_count_nxt;
    end
  end

  // Output channel.
  assign q_head              = q_mem[q_rd_r];
  assign out_res.valid       = (q_count_r != '0);
  assign out_res.result_kind = q_head.kind;
  assign out_res.cut_row     = q_head.cut_row;
  assign out_res.cut_total   = q_head.cut_total;
  assign out_res.enough_cuts = q_head.enough;
  assign out_res.last_result = q_head.last;

  // The queue never holds more entries than it has.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // A status result always ends the results of its pixel.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.result_kind == tlcf_pkg::KIND_STATUS |-> out_res.last_result)
    else $error("status result without last_result");

  // A cut result counts itself and carries no status flag.
  a_cut_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.result_kind == tlcf_pkg::KIND_CUT
      |-> !out_res.enough_cuts && out_res.cut_total != '0)
    else $error("malformed cut result");

  // The image end leaves a cleared image state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && img_end |=> row_r == '0 && cuts_r == '0 && !blank_r && col_r == '0)
    else $error("image state not cleared at image end");

endmodule
